// ===== hw/rtl/trae_pkg.sv =====
package trae_pkg;

	localparam int RULE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam int LIST_IW = $clog2(MAX_RESULTS);
	localparam int LIST_NW = $clog2(MAX_RESULTS + 1);
	localparam int FIRED_W = 7;

	localparam logic [1:0] OPC_ADD = 2'd0;
	localparam logic [1:0] OPC_SAMPLE = 2'd1;
	localparam logic [1:0] OPC_CHECK = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [2:0] CMP_GT = 3'd0;
	localparam logic [2:0] CMP_GTE = 3'd1;
	localparam logic [2:0] CMP_LT = 3'd2;
	localparam logic [2:0] CMP_LTE = 3'd3;
	localparam logic [2:0] CMP_EQ = 3'd4;
	localparam logic [2:0] CMP_NEQ = 3'd5;
	localparam logic [2:0] CMP_STALE = 3'd6;

	localparam logic [1:0] LVL_INFO = 2'd0;
	localparam logic [1:0] LVL_WARN = 2'd1;
	localparam logic [1:0] LVL_ERROR = 2'd2;

	typedef struct packed {
		logic [7:0]         key;
		logic               stale;
		logic [2:0]         cmp;
		logic [1:0]         sev;
		logic signed [31:0] limit;
		logic [31:0]        hold;
		logic [7:0]         evt;
	} rule_t;

	typedef struct packed {
		logic [31:0] last_fire;
		logic        fired;
		logic        seen;
	} dyn_t;

	typedef struct packed {
		logic load;
		logic add;
		logic walk_rd;
		logic walk_ev;
		logic emit_rd;
		logic emit_out;
		logic emit_last;
		logic single_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [LIST_NW-1:0] list_n;
	} stat_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

endpackage

// ===== hw/rtl/threshold_rule_alarm_engine_core.sv =====
// An add or an undefined opcode gives one result. A sample or a stale check reads and
// then evaluates each loaded rule in turn; a sample then gives one result.
// A stale check gives one result per firing rule, at most MAX_RESULTS, and none if no rule fires.
// The next item is taken only once the last one is finished, while busy is low.
// Results are single-cycle strobes on done; the receiver cannot stall them.
// Reset clears the rule count and the totals; table contents need no reset.
module threshold_rule_alarm_engine_core #(
	parameter int RULE_DEPTH = trae_pkg::RULE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   opcode,
	input  logic [7:0]                   key_id,
	input  logic signed [31:0]           sample_value,
	input  logic [31:0]                  now_seconds,
	input  logic                         rule_kind,
	input  logic [2:0]                   rule_op,
	input  logic [1:0]                   rule_level,
	input  logic signed [31:0]           rule_threshold,
	input  logic [31:0]                  rule_cooldown,
	input  logic [7:0]                   rule_event_id,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [trae_pkg::FIRED_W-1:0] fired_count,
	output logic [7:0]                   event_code,
	output logic [1:0]                   event_level,
	output logic [2:0]                   event_op,
	output logic signed [31:0]           event_threshold,
	output logic signed [31:0]           event_value,
	output logic                         last,
	output logic [31:0]                  sample_tally,
	output logic [31:0]                  info_tally,
	output logic [31:0]                  warn_tally,
	output logic [31:0]                  error_tally
);

	localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CNT_W = $clog2(RULE_DEPTH + 1);

	trae_pkg::cmd_t  cmd;
	trae_pkg::stat_t stat;
	logic [CNT_W-1:0] loaded;
	logic [IDX_W-1:0] idx;
	logic [trae_pkg::LIST_IW-1:0] k;

	trae_ctrl #(.RULE_DEPTH(RULE_DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode), .stat(stat),
		.loaded(loaded), .busy(busy), .cmd(cmd), .idx(idx), .k(k)
	);

	trae_datapath #(.RULE_DEPTH(RULE_DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx(idx), .k(k), .opcode(opcode),
		.key_id(key_id), .sample_value(sample_value), .now_seconds(now_seconds),
		.rule_kind(rule_kind), .rule_op(rule_op), .rule_level(rule_level),
		.rule_threshold(rule_threshold), .rule_cooldown(rule_cooldown),
		.rule_event_id(rule_event_id), .stat(stat), .loaded(loaded), .done(done),
		.status(status), .fired_count(fired_count), .event_code(event_code),
		.event_level(event_level), .event_op(event_op),
		.event_threshold(event_threshold), .event_value(event_value), .last(last),
		.sample_tally(sample_tally), .info_tally(info_tally),
		.warn_tally(warn_tally), .error_tally(error_tally)
	);

endmodule

// ===== hw/rtl/trae_ctrl.sv =====
module trae_ctrl #(
	parameter int RULE_DEPTH = trae_pkg::RULE_DEPTH_DEF,
	parameter int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1,
	parameter int CNT_W = $clog2(RULE_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 opcode,
	input  trae_pkg::stat_t            stat,
	input  logic [CNT_W-1:0]           loaded,
	output logic                       busy,
	output trae_pkg::cmd_t             cmd,
	output logic [IDX_W-1:0]           idx,
	output logic [trae_pkg::LIST_IW-1:0] k
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD = 3'd1;
	localparam logic [2:0] S_WRD = 3'd2;
	localparam logic [2:0] S_WEV = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;
	localparam logic [2:0] S_ERD = 3'd5;
	localparam logic [2:0] S_EOUT = 3'd6;

	logic [2:0] state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [trae_pkg::LIST_IW-1:0] k_q, k_d;
	logic walk_end, emit_end;

	assign walk_end = (CNT_W'(idx_q) + CNT_W'(1)) == loaded;
	assign emit_end = (trae_pkg::LIST_NW'(k_q) + trae_pkg::LIST_NW'(1)) == stat.list_n;
	assign busy = state_q != S_IDLE;
	assign idx = idx_q;
	assign k = k_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		k_d = k_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					idx_d = '0;
					k_d = '0;
					if (opcode == trae_pkg::OPC_ADD) begin
						state_d = S_ADD;
					end else if ((opcode == trae_pkg::OPC_SAMPLE ||
					              opcode == trae_pkg::OPC_CHECK) && loaded != '0) begin
						state_d = S_WRD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_IDLE;
			end
			S_WRD: begin
				cmd.walk_rd = 1'b1;
				state_d = S_WEV;
			end
			S_WEV: begin
				cmd.walk_ev = 1'b1;
				if (walk_end) begin
					state_d = S_FIN;
				end else begin
					idx_d = idx_q + IDX_W'(1);
					state_d = S_WRD;
				end
			end
			S_FIN: begin
				if (stat.op == trae_pkg::OPC_CHECK) begin
					state_d = (stat.list_n == '0) ? S_IDLE : S_ERD;
				end else begin
					cmd.single_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d = S_EOUT;
			end
			S_EOUT: begin
				cmd.emit_out = 1'b1;
				cmd.emit_last = emit_end;
				if (emit_end) begin
					state_d = S_IDLE;
				end else begin
					k_d = k_q + trae_pkg::LIST_IW'(1);
					state_d = S_ERD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			k_q <= k_d;
		end
	end

endmodule

// ===== hw/rtl/trae_datapath.sv =====
module trae_datapath #(
	parameter int RULE_DEPTH = trae_pkg::RULE_DEPTH_DEF,
	parameter int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1,
	parameter int CNT_W = $clog2(RULE_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  trae_pkg::cmd_t               cmd,
	input  logic [IDX_W-1:0]             idx,
	input  logic [trae_pkg::LIST_IW-1:0] k,
	input  logic [1:0]                   opcode,
	input  logic [7:0]                   key_id,
	input  logic signed [31:0]           sample_value,
	input  logic [31:0]                  now_seconds,
	input  logic                         rule_kind,
	input  logic [2:0]                   rule_op,
	input  logic [1:0]                   rule_level,
	input  logic signed [31:0]           rule_threshold,
	input  logic [31:0]                  rule_cooldown,
	input  logic [7:0]                   rule_event_id,
	output trae_pkg::stat_t              stat,
	output logic [CNT_W-1:0]             loaded,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [trae_pkg::FIRED_W-1:0] fired_count,
	output logic [7:0]                   event_code,
	output logic [1:0]                   event_level,
	output logic [2:0]                   event_op,
	output logic signed [31:0]           event_threshold,
	output logic signed [31:0]           event_value,
	output logic                         last,
	output logic [31:0]                  sample_tally,
	output logic [31:0]                  info_tally,
	output logic [31:0]                  warn_tally,
	output logic [31:0]                  error_tally
);

	trae_pkg::rule_t tab_mem [RULE_DEPTH];
	trae_pkg::dyn_t  dyn_mem [RULE_DEPTH];
	trae_pkg::rule_t tab_rd_q, first_q, new_rule;
	trae_pkg::dyn_t  dyn_rd_q, dyn_wr;
	logic [IDX_W-1:0] list_q [trae_pkg::MAX_RESULTS];
	logic [IDX_W-1:0] rd_addr, ev_idx_q;

	logic [1:0]                   op_q;
	logic [7:0]                   key_q;
	logic signed [31:0]           val_q;
	logic [31:0]                  now_q;
	logic                         kind_q;
	logic [2:0]                   rop_q;
	logic [1:0]                   lvl_q;
	logic signed [31:0]           thr_q;
	logic [31:0]                  cool_q;
	logic [7:0]                   evt_q;
	logic [CNT_W-1:0]             loaded_q;
	logic [trae_pkg::LIST_NW-1:0] list_n_q;
	logic [trae_pkg::FIRED_W-1:0] fired_q;
	logic [31:0]                  samp_q, info_q, warn_q, err_q;

	logic [32:0] elapsed;
	logic        suppress, hit, key_match, consider, rec, dyn_we;

	assign stat.op = op_q;
	assign stat.list_n = list_n_q;
	assign loaded = loaded_q;
	assign rd_addr = cmd.emit_rd ? list_q[k] : idx;

	assign new_rule.key = key_q;
	assign new_rule.stale = kind_q;
	assign new_rule.cmp = kind_q ? trae_pkg::CMP_GT : rop_q;
	assign new_rule.sev = lvl_q;
	assign new_rule.limit = thr_q;
	assign new_rule.hold = cool_q;
	assign new_rule.evt = evt_q;

	// A negative difference (the clock went back) holds off a fired rule with a nonzero hold.
	always_comb begin
		elapsed = {1'b0, now_q} - {1'b0, dyn_rd_q.last_fire};
		suppress = (tab_rd_q.hold != '0) && dyn_rd_q.fired &&
		           (elapsed[32] || (elapsed[31:16] == '0 &&
		            {elapsed[15:0], 16'h0000} < tab_rd_q.hold));
		if (tab_rd_q.stale) begin
			hit = val_q > tab_rd_q.limit;
		end else begin
			unique case (tab_rd_q.cmp)
				trae_pkg::CMP_GT:  hit = val_q > tab_rd_q.limit;
				trae_pkg::CMP_GTE: hit = val_q >= tab_rd_q.limit;
				trae_pkg::CMP_LT:  hit = val_q < tab_rd_q.limit;
				trae_pkg::CMP_LTE: hit = val_q <= tab_rd_q.limit;
				trae_pkg::CMP_EQ:  hit = val_q == tab_rd_q.limit;
				trae_pkg::CMP_NEQ: hit = val_q != tab_rd_q.limit;
				default:           hit = 1'b0;
			endcase
		end
		key_match = tab_rd_q.key == key_q;
		consider = tab_rd_q.stale && !dyn_rd_q.seen;
		if (op_q == trae_pkg::OPC_SAMPLE) begin
			rec = key_match && hit && !suppress;
			dyn_we = key_match;
		end else begin
			rec = consider && !suppress;
			dyn_we = rec;
		end
		dyn_wr = dyn_rd_q;
		if (op_q == trae_pkg::OPC_SAMPLE && tab_rd_q.stale) begin
			dyn_wr.seen = 1'b1;
		end
		if (rec) begin
			dyn_wr.last_fire = now_q;
			dyn_wr.fired = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && !(kind_q && thr_q < 0) && loaded_q != CNT_W'(RULE_DEPTH)) begin
			tab_mem[loaded_q[IDX_W-1:0]] <= new_rule;
			dyn_mem[loaded_q[IDX_W-1:0]] <= '0;
		end else if (cmd.walk_ev && dyn_we) begin
			dyn_mem[ev_idx_q] <= dyn_wr;
		end
		if (cmd.walk_rd || cmd.emit_rd) begin
			tab_rd_q <= tab_mem[rd_addr];
			dyn_rd_q <= dyn_mem[rd_addr];
			ev_idx_q <= rd_addr;
		end
		if (cmd.load) begin
			key_q <= key_id;
			val_q <= sample_value;
			now_q <= now_seconds;
			kind_q <= rule_kind;
			rop_q <= rule_op;
			lvl_q <= rule_level;
			thr_q <= rule_threshold;
			cool_q <= rule_cooldown;
			evt_q <= rule_event_id;
		end
		if (cmd.walk_ev && rec) begin
			if (fired_q == '0) begin
				first_q <= tab_rd_q;
			end
			if (list_n_q != trae_pkg::LIST_NW'(trae_pkg::MAX_RESULTS)) begin
				list_q[list_n_q[trae_pkg::LIST_IW-1:0]] <= ev_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			loaded_q <= '0;
			list_n_q <= '0;
			fired_q <= '0;
			samp_q <= '0;
			info_q <= '0;
			warn_q <= '0;
			err_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.add || cmd.single_out || cmd.emit_out;
			if (cmd.load) begin
				op_q <= opcode;
				list_n_q <= '0;
				fired_q <= '0;
				if (opcode == trae_pkg::OPC_SAMPLE) begin
					samp_q <= trae_pkg::sat_inc(samp_q);
				end
			end
			if (cmd.add && !(kind_q && thr_q < 0) && loaded_q != CNT_W'(RULE_DEPTH)) begin
				loaded_q <= loaded_q + CNT_W'(1);
			end
			if (cmd.walk_ev && rec) begin
				fired_q <= fired_q + trae_pkg::FIRED_W'(1);
				if (list_n_q != trae_pkg::LIST_NW'(trae_pkg::MAX_RESULTS)) begin
					list_n_q <= list_n_q + trae_pkg::LIST_NW'(1);
				end
				unique case (tab_rd_q.sev)
					trae_pkg::LVL_INFO:  info_q <= trae_pkg::sat_inc(info_q);
					trae_pkg::LVL_WARN:  warn_q <= trae_pkg::sat_inc(warn_q);
					trae_pkg::LVL_ERROR: err_q <= trae_pkg::sat_inc(err_q);
					default: ;
				endcase
			end
		end
	end

	// Result fields; the counters are read straight from the running totals.
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			if (kind_q && thr_q < 0) begin
				status <= trae_pkg::ST_INVALID;
			end else if (loaded_q == CNT_W'(RULE_DEPTH)) begin
				status <= trae_pkg::ST_FULL;
			end else begin
				status <= trae_pkg::ST_OK;
			end
			fired_count <= '0;
			event_code <= '0;
			event_level <= '0;
			event_op <= '0;
			event_threshold <= '0;
			event_value <= '0;
			last <= 1'b1;
		end else if (cmd.emit_out) begin
			status <= trae_pkg::ST_OK;
			fired_count <= fired_q;
			event_code <= tab_rd_q.evt;
			event_level <= tab_rd_q.sev;
			event_op <= trae_pkg::CMP_STALE;
			event_threshold <= tab_rd_q.limit;
			event_value <= tab_rd_q.limit;
			last <= cmd.emit_last;
		end else if (cmd.single_out) begin
			status <= (op_q == trae_pkg::OPC_SAMPLE) ? trae_pkg::ST_OK : trae_pkg::ST_INVALID;
			// Of the opcodes that reach this branch only a sample walks the table, so the count is zero for any other opcode.
			fired_count <= fired_q;
			last <= 1'b1;
			if (fired_q != '0) begin
				event_code <= first_q.evt;
				event_level <= first_q.sev;
				event_op <= first_q.stale ? trae_pkg::CMP_STALE : first_q.cmp;
				event_threshold <= first_q.limit;
				event_value <= val_q;
			end else begin
				event_code <= '0;
				event_level <= '0;
				event_op <= '0;
				event_threshold <= '0;
				event_value <= '0;
			end
		end
	end

	assign sample_tally = samp_q;
	assign info_tally = info_q;
	assign warn_tally = warn_q;
	assign error_tally = err_q;

endmodule
